FILE: design/moyal_inverse_cdf_sampler_macros.svh
// Assertion macros used by the checker of the Moyal sampler.
`ifndef MOYAL_INVERSE_CDF_SAMPLER_MACROS_SVH
`define MOYAL_INVERSE_CDF_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge outside reset.
`define MSMP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge outside reset.
`define MSMP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/msmp_pkg.sv
// Types, constants and the coefficient table of the Moyal sampler.
package msmp_pkg;

    localparam int ROM_DEPTH = 64;
    localparam int NW        = 5;

    localparam logic [31:0] HALF_SQRT_PI = 32'd3806315662;
    localparam logic [63:0] TWO_LN2      = 64'hB17217F7D1CF79AB;
    localparam logic [63:0] ONE_Q32      = 64'h0000_0001_0000_0000;

    typedef logic [63:0] t_q64;
    typedef t_q64 t_rom [ROM_DEPTH];

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_LOG_ZERO = 2'd1,
        ST_SAT      = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        CFG_MODE  = 2'd0,
        CFG_SCALE = 2'd1,
        CFG_TERMS = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic          valid;
        logic [NW-1:0] n;
        t_q64          sum;
        t_q64          term;
        logic          use_term;
        logic [62:0]   pw;
        logic [62:0]   t2;
    } t_ser;

    typedef struct packed {
        logic        valid;
        logic        zero;
        logic [5:0]  p;
        logic [62:0] m;
        logic [31:0] frac;
    } t_lg;

    typedef struct packed {
        logic        valid;
        logic [31:0] data;
        t_status     status;
    } t_res;

    function automatic t_q64 sat_add(t_q64 a, t_q64 b);
        logic [64:0] r;
        r = {1'b0, a} + {1'b0, b};
        return r[64] ? '1 : r[63:0];
    endfunction

    function automatic t_q64 rom_mul_shr(t_q64 a, t_q64 b);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        return (p[127:96] != '0) ? '1 : p[95:32];
    endfunction

    // Truncating long division, evaluated only while the table is built.
    function automatic t_q64 const_div(t_q64 num, t_q64 den);
        logic [64:0] rem;
        t_q64        quo;
        rem = '0;
        quo = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[63:0], num[i]};
            if (rem >= {1'b0, den}) begin
                rem    = rem - {1'b0, den};
                quo[i] = 1'b1;
            end
        end
        return quo;
    endfunction

    // Series coefficients a_k = c_k / (2k+1), built at elaboration.
    function automatic t_rom build_rom();
        t_rom c;
        t_rom a;
        t_q64 acc;
        t_q64 den;
        c[0] = ONE_Q32;
        a[0] = ONE_Q32;
        for (int k = 1; k < ROM_DEPTH; k++) begin
            acc = '0;
            for (int m = 0; m < k; m++) begin
                den = 64'(m + 1) * 64'(2 * m + 1);
                acc = sat_add(acc, const_div(rom_mul_shr(c[m], c[k-1-m]), den));
            end
            c[k] = acc;
            a[k] = const_div(acc, 64'(2 * k + 1));
        end
        return a;
    endfunction

    localparam t_rom A_ROM = build_rom();

endpackage

FILE: design/moyal_inverse_cdf_sampler.sv
// Moyal sampler: each transaction carries one uniform word u and returns one
// variate x = mode - 2*sigma*ln(sqrt(2)*S), where S is the inverse-erfc series in
// t = sqrt(pi)/2*(1-u), as signed Q16.16 with a status code in tuser. A new
// transaction is taken every cycle; the path from input to the output register
// runs through the chain of MAX_TERMS series cells of two stages each and the 32
// squaring steps of the logarithm. The pipeline halts only while the output skid
// stage is full.
module moyal_inverse_cdf_sampler import msmp_pkg::*; #(
    parameter int MAX_TERMS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [39:0] i_s_axis_tdata,   // [32:0] uniform_in, [39:33] zero
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,   // [31:0] variate_out
    output logic [1:0]  o_m_axis_tuser,   // [1:0] status
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [31:0]   r_mode;
    logic [30:0]   r_scale;
    logic [4:0]    r_terms;

    logic          w_ce;
    logic          w_take;

    logic          r1_valid, r2_valid, r3_valid, r4_valid;
    logic [32:0]   r1_d;
    logic [NW-1:0] r1_n, r2_n, r3_n, r4_n;
    logic [62:0]   r2_t, r3_t, r4_t;
    logic [61:0]   r3_hh;
    logic [62:0]   r3_hl;
    logic [63:0]   r3_ll;
    logic [62:0]   r4_t2;
    logic [32:0]   n1_u;
    logic [NW-1:0] n1_n;
    logic [64:0]   w_tprod;
    logic [127:0]  w_sq;

    t_ser          w_ser [MAX_TERMS+1];

    logic          rf_valid, rl1_valid, rl2_valid;
    logic          rf_zero, rl1_zero, rl2_zero;
    t_q64          rf_sum, rl1_sum;
    logic [5:0]    rl1_p, rl2_p, n_l1_p;
    logic [62:0]   rl2_m, n_l2_m;
    logic [63:0]   w_shift;

    t_lg           w_lg [33];
    t_res          w_res;

    logic          r_out_valid;
    logic [31:0]   r_out_data;
    t_status       r_out_status;
    logic          r_skid_valid;
    logic [31:0]   r_skid_data;
    t_status       r_skid_status;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= '0;
            r_scale <= 31'd65536;
            r_terms <= 5'd8;
        end else if (i_cfg_valid) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_MODE:  r_mode  <= i_cfg_data;
                CFG_SCALE: r_scale <= i_cfg_data[30:0];
                CFG_TERMS: r_terms <= i_cfg_data[4:0];
                default: ;
            endcase
        end
    end

    assign w_ce            = !r_skid_valid;
    assign o_s_axis_tready = w_ce;
    assign w_take          = i_s_axis_tvalid && w_ce;

    always_comb begin
        n1_u = i_s_axis_tdata[32:0];
        if (n1_u > 33'h1_0000_0000) begin
            n1_u = 33'h1_0000_0000;
        end
        n1_n = r_terms;
        if (r_terms == '0) begin
            n1_n = NW'(1);
        end else if (int'(r_terms) > MAX_TERMS) begin
            n1_n = NW'(MAX_TERMS);
        end
        w_tprod = 65'(r1_d) * 65'(HALF_SQRT_PI);
        w_sq    = (128'(r3_hh) << 64) + (128'(r3_hl) << 33) + 128'(r3_ll);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
            r4_valid <= 1'b0;
        end else if (w_ce) begin
            r1_valid <= w_take;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
            r4_valid <= r3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            r1_d  <= 33'h1_0000_0000 - n1_u;
            r1_n  <= n1_n;
            r2_t  <= w_tprod[63:1];
            r2_n  <= r1_n;
            r3_hh <= r2_t[62:32] * r2_t[62:32];
            r3_hl <= r2_t[62:32] * r2_t[31:0];
            r3_ll <= r2_t[31:0] * r2_t[31:0];
            r3_t  <= r2_t;
            r3_n  <= r2_n;
            r4_t2 <= w_sq[125:63];
            r4_t  <= r3_t;
            r4_n  <= r3_n;
        end
    end

    always_comb begin
        w_ser[0]          = '0;
        w_ser[0].valid    = r4_valid;
        w_ser[0].n        = r4_n;
        w_ser[0].pw       = r4_t;
        w_ser[0].t2       = r4_t2;
    end

    for (genvar k = 0; k < MAX_TERMS; k++) begin : g_cell
        msmp_series_cell #(.K(k)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_d     (w_ser[k]),
            .o_d     (w_ser[k+1])
        );
    end

    always_comb begin
        n_l1_p = '0;
        for (int i = 0; i < 64; i++) begin
            if (rf_sum[i]) begin
                n_l1_p = 6'(i);
            end
        end
        w_shift = rl1_sum << (6'd62 - rl1_p);
        n_l2_m  = (rl1_p == 6'd63) ? rl1_sum[63:1] : w_shift[62:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            rf_valid  <= 1'b0;
            rl1_valid <= 1'b0;
            rl2_valid <= 1'b0;
        end else if (w_ce) begin
            rf_valid  <= w_ser[MAX_TERMS].valid;
            rl1_valid <= rf_valid;
            rl2_valid <= rl1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ce) begin
            rf_sum   <= w_ser[MAX_TERMS].use_term
                      ? sat_add(w_ser[MAX_TERMS].sum, w_ser[MAX_TERMS].term)
                      : w_ser[MAX_TERMS].sum;
            rf_zero  <= w_ser[MAX_TERMS].use_term
                      ? (sat_add(w_ser[MAX_TERMS].sum, w_ser[MAX_TERMS].term) == '0)
                      : (w_ser[MAX_TERMS].sum == '0);
            rl1_sum  <= rf_sum;
            rl1_p    <= n_l1_p;
            rl1_zero <= rf_zero;
            rl2_m    <= n_l2_m;
            rl2_p    <= rl1_p;
            rl2_zero <= rl1_zero;
        end
    end

    always_comb begin
        w_lg[0]       = '0;
        w_lg[0].valid = rl2_valid;
        w_lg[0].zero  = rl2_zero;
        w_lg[0].p     = rl2_p;
        w_lg[0].m     = rl2_m;
    end

    for (genvar i = 0; i < 32; i++) begin : g_log
        msmp_log2_step #(.BIT(31 - i)) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ce    (w_ce),
            .i_d     (w_lg[i]),
            .o_d     (w_lg[i+1])
        );
    end

    msmp_scale u_scale (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ce    (w_ce),
        .i_d     (w_lg[32]),
        .i_mode  (r_mode),
        .i_scale (r_scale),
        .o_res   (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_out_valid && !i_m_axis_tready) begin
            if (w_ce && w_res.valid) begin
                r_skid_valid <= 1'b1;
            end
        end else if (r_skid_valid) begin
            r_out_valid  <= 1'b1;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid <= w_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_out_valid && !i_m_axis_tready) begin
            if (w_ce && w_res.valid) begin
                r_skid_data   <= w_res.data;
                r_skid_status <= w_res.status;
            end
        end else if (r_skid_valid) begin
            r_out_data   <= r_skid_data;
            r_out_status <= r_skid_status;
        end else begin
            r_out_data   <= w_res.data;
            r_out_status <= w_res.status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;
    assign o_m_axis_tuser  = r_out_status;

endmodule

FILE: design/msmp_series_cell.sv
// One series term: coefficient product, running sum and next odd power.
module msmp_series_cell import msmp_pkg::*; #(
    parameter int K = 0
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_ce,
    input  t_ser i_d,
    output t_ser o_d
);

    localparam t_q64 COEF = A_ROM[K];

    logic          r_a_valid;
    logic [NW-1:0] r_a_n;
    t_q64          r_a_sum;
    logic [62:0]   r_a_t2;
    logic [63:0]   r_c_ll, r_c_lh, r_c_hl, r_c_hh;
    logic [63:0]   r_p_ll, r_p_lh, r_p_hl, r_p_hh;
    t_q64          n_a_sum;
    logic [63:0]   n_c_ll, n_c_lh, n_c_hl, n_c_hh;
    logic [63:0]   n_p_ll, n_p_lh, n_p_hl, n_p_hh;
    logic [127:0]  w_cprod, w_pprod;
    t_ser          r_b, n_b;

    always_comb begin
        n_a_sum = i_d.use_term ? sat_add(i_d.sum, i_d.term) : i_d.sum;
        n_c_ll  = COEF[31:0]  * i_d.pw[31:0];
        n_c_lh  = COEF[31:0]  * {1'b0, i_d.pw[62:32]};
        n_c_hl  = COEF[63:32] * i_d.pw[31:0];
        n_c_hh  = COEF[63:32] * {1'b0, i_d.pw[62:32]};
        n_p_ll  = i_d.pw[31:0] * i_d.t2[31:0];
        n_p_lh  = i_d.pw[31:0] * {1'b0, i_d.t2[62:32]};
        n_p_hl  = {1'b0, i_d.pw[62:32]} * i_d.t2[31:0];
        n_p_hh  = {1'b0, i_d.pw[62:32]} * {1'b0, i_d.t2[62:32]};
    end

    always_comb begin
        w_cprod = (128'(r_c_hh) << 64) + (128'(r_c_hl) << 32)
                + (128'(r_c_lh) << 32) + 128'(r_c_ll);
        w_pprod = (128'(r_p_hh) << 64) + (128'(r_p_hl) << 32)
                + (128'(r_p_lh) << 32) + 128'(r_p_ll);
        n_b          = '0;
        n_b.valid    = r_a_valid;
        n_b.n        = r_a_n;
        n_b.sum      = r_a_sum;
        n_b.term     = (w_cprod[127:111] != '0) ? '1 : w_cprod[110:47];
        n_b.use_term = (int'(r_a_n) > K);
        n_b.pw       = w_pprod[125:63];
        n_b.t2       = r_a_t2;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b       <= '0;
        end else if (i_ce) begin
            r_a_valid <= i_d.valid;
            r_b       <= n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a_n       <= i_d.n;
            r_a_sum     <= n_a_sum;
            r_a_t2      <= i_d.t2;
            r_c_ll      <= n_c_ll;
            r_c_lh      <= n_c_lh;
            r_c_hl      <= n_c_hl;
            r_c_hh      <= n_c_hh;
            r_p_ll      <= n_p_ll;
            r_p_lh      <= n_p_lh;
            r_p_hl      <= n_p_hl;
            r_p_hh      <= n_p_hh;
        end
    end

    assign o_d = r_b;

endmodule

FILE: design/msmp_log2_step.sv
// One fraction bit of log2 by squaring the normalised mantissa.
module msmp_log2_step import msmp_pkg::*; #(
    parameter int BIT = 31
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_ce,
    input  t_lg  i_d,
    output t_lg  o_d
);

    logic         r_a_valid;
    logic         r_a_zero;
    logic [5:0]   r_a_p;
    logic [31:0]  r_a_frac;
    logic [61:0]  r_hh;
    logic [62:0]  r_hl;
    logic [63:0]  r_ll;
    logic [61:0]  n_hh;
    logic [62:0]  n_hl;
    logic [63:0]  n_ll;
    logic [127:0] w_sq;
    logic [63:0]  w_r;
    t_lg          r_b, n_b;

    always_comb begin
        n_hh = i_d.m[62:32] * i_d.m[62:32];
        n_hl = i_d.m[62:32] * i_d.m[31:0];
        n_ll = i_d.m[31:0]  * i_d.m[31:0];
    end

    always_comb begin
        w_sq = (128'(r_hh) << 64) + (128'(r_hl) << 33) + 128'(r_ll);
        w_r  = w_sq[125:62];
        n_b       = '0;
        n_b.valid = r_a_valid;
        n_b.zero  = r_a_zero;
        n_b.p     = r_a_p;
        n_b.frac  = r_a_frac;
        if (w_r[63]) begin
            n_b.m         = w_r[63:1];
            n_b.frac[BIT] = 1'b1;
        end else begin
            n_b.m = w_r[62:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b       <= '0;
        end else if (i_ce) begin
            r_a_valid <= i_d.valid;
            r_b       <= n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_a_zero <= i_d.zero;
            r_a_p    <= i_d.p;
            r_a_frac <= i_d.frac;
            r_hh     <= n_hh;
            r_hl     <= n_hl;
            r_ll     <= n_ll;
        end
    end

    assign o_d = r_b;

endmodule

FILE: design/msmp_scale.sv
// Scaling of the logarithm by 2 ln 2 and sigma, offset by the mode and saturation.
module msmp_scale import msmp_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_ce,
    input  t_lg         i_d,
    input  logic [31:0] i_mode,
    input  logic [30:0] i_scale,
    output t_res        o_res
);

    // Valid and zero flags travel through the six stages.
    logic [4:0]   r_valid;
    logic [4:0]   r_zero;
    logic [4:0]   r_neg;
    logic [39:0]  r_mag;
    logic [63:0]  r_w_ll, r_w_lh;
    logic [39:0]  r_w_hl, r_w_hh;
    logic [39:0]  r_w;
    logic [62:0]  r_d_lo;
    logic [38:0]  r_d_hi;
    logic [39:0]  r_delta;
    t_res         r_res;

    logic [7:0]   w_e;
    logic [40:0]  w_v;
    logic [40:0]  w_vabs;
    logic [127:0] w_wprod;
    logic [71:0]  w_dprod;
    logic [41:0]  w_xm, w_dd, w_x;
    t_res         n_res;

    always_comb begin
        w_e    = {2'b00, i_d.p} - 8'd48;
        w_v    = {w_e[7], w_e, 32'b0} + {9'b0, i_d.frac} + 41'h0_8000_0000;
        w_vabs = w_v[40] ? (~w_v + 41'd1) : w_v;
    end

    always_comb begin
        w_wprod = (128'(r_w_hh) << 64) + (128'(r_w_hl) << 32)
                + (128'(r_w_lh) << 32) + 128'(r_w_ll);
        w_dprod = (72'(r_d_hi) << 32) + 72'(r_d_lo);
    end

    always_comb begin
        w_xm = {{10{i_mode[31]}}, i_mode};
        w_dd = {2'b00, r_delta};
        w_x  = r_neg[4] ? (w_xm + w_dd) : (w_xm - w_dd);
        n_res       = '0;
        n_res.valid = r_valid[4];
        if (r_zero[4]) begin
            n_res.data   = 32'h7FFF_FFFF;
            n_res.status = ST_LOG_ZERO;
        end else if ($signed(w_x) > 42'sd2147483647) begin
            n_res.data   = 32'h7FFF_FFFF;
            n_res.status = ST_SAT;
        end else if ($signed(w_x) < -42'sd2147483648) begin
            n_res.data   = 32'h8000_0000;
            n_res.status = ST_SAT;
        end else begin
            n_res.data   = w_x[31:0];
            n_res.status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_ce) begin
            r_valid <= {r_valid[3:0], i_d.valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ce) begin
            r_zero  <= {r_zero[3:0], i_d.zero};
            r_neg   <= {r_neg[3:0], w_v[40]};
            r_mag   <= w_vabs[39:0];
            r_w_ll  <= r_mag[31:0] * TWO_LN2[31:0];
            r_w_lh  <= r_mag[31:0] * TWO_LN2[63:32];
            r_w_hl  <= r_mag[39:32] * TWO_LN2[31:0];
            r_w_hh  <= r_mag[39:32] * TWO_LN2[63:32];
            r_w     <= w_wprod[102:63];
            r_d_lo  <= r_w[31:0] * i_scale;
            r_d_hi  <= r_w[39:32] * i_scale;
            r_delta <= w_dprod[71:32];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res <= '0;
        end else if (i_ce) begin
            r_res <= n_res;
        end
    end

    assign o_res = r_res;

endmodule

FILE: design/msmp_checker.sv
// Port-level checks of the Moyal sampler and their binding to the top level.
`include "moyal_inverse_cdf_sampler_macros.svh"

module msmp_checker import msmp_pkg::*; (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [31:0] o_m_axis_tdata,
    input logic [1:0]  o_m_axis_tuser
);

    `MSMP_ASSERT_NXT(a_out_hold, o_m_axis_tvalid && !i_m_axis_tready, o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tuser), "Stalled result changed")
    `MSMP_ASSERT_IMP(a_zero_max, o_m_axis_tvalid && (o_m_axis_tuser == ST_LOG_ZERO), o_m_axis_tdata == 32'h7FFF_FFFF, "Zero sum without largest value")
    `MSMP_ASSERT_IMP(a_sat_ext, o_m_axis_tvalid && (o_m_axis_tuser == ST_SAT), (o_m_axis_tdata == 32'h7FFF_FFFF) || (o_m_axis_tdata == 32'h8000_0000), "Saturated result not at an extreme")
    `MSMP_ASSERT_IMP(a_stall_src, !o_s_axis_tready, o_m_axis_tvalid, "Input stalled with no result waiting")

endmodule

bind moyal_inverse_cdf_sampler msmp_checker u_msmp_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .o_m_axis_tuser  (o_m_axis_tuser)
);

FILE: dv/tb_moyal_inverse_cdf_sampler.sv
// Self-checking testbench of the Moyal inverse-CDF sampler, with a stream driver and monitor.
`timescale 1ns / 100ps

module tb_moyal_inverse_cdf_sampler;
    import msmp_pkg::*;

    localparam int MAX_TERMS = 16;
    localparam int HOLD_CYCLES = 400;
    localparam int DRAIN_CYCLES = 150;

    typedef struct {
        logic [31:0] variate;
        t_status     status;
    } t_variate_res;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_axis_tvalid;
    logic        o_s_axis_tready;
    logic [39:0] i_s_axis_tdata;
    logic        o_m_axis_tvalid;
    logic        i_m_axis_tready;
    logic [31:0] o_m_axis_tdata;
    logic [1:0]  o_m_axis_tuser;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [31:0] i_cfg_data;

    logic [32:0]  pending_uniform[$];
    t_variate_res expected_variates[$];
    logic [63:0]  series_coef[MAX_TERMS];

    logic signed [31:0] mode_q;
    logic [30:0]        scale_q;
    logic [4:0]         terms_q;

    logic send_pause;
    logic quiet;
    logic hold_go;
    int   hold_cnt;
    int   errors;

    moyal_inverse_cdf_sampler #(.MAX_TERMS(MAX_TERMS)) dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2ms;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int s);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        if ((p >> (64 + s)) != 0)
            return '1;
        return 64'(p >> s);
    endfunction

    function automatic logic [63:0] add_clip(logic [63:0] a, logic [63:0] b);
        logic [64:0] r;
        r = {1'b0, a} + {1'b0, b};
        return r[64] ? '1 : r[63:0];
    endfunction

    function automatic t_variate_res predict_variate(logic [32:0] uniform);
        logic [63:0] u, d, t, t2, pw, sum, m, frac, mag, w, delta;
        logic signed [63:0] v;
        logic signed [66:0] x;
        int n, p;
        t_variate_res r;
        u = {31'b0, uniform};
        if (u > ONE_Q32)
            u = ONE_Q32;
        n = terms_q;
        if (n < 1)
            n = 1;
        if (n > MAX_TERMS)
            n = MAX_TERMS;
        d = ONE_Q32 - u;
        t = (d * {32'b0, HALF_SQRT_PI}) >> 1;
        t2 = mul_shift(t, t, 63);
        pw = t;
        sum = '0;
        for (int k = 0; k < n; k++) begin
            sum = add_clip(sum, mul_shift(series_coef[k], pw, 47));
            pw = mul_shift(pw, t2, 63);
        end
        if (sum == 0) begin
            r.variate = 32'h7FFF_FFFF;
            r.status = ST_LOG_ZERO;
            return r;
        end
        p = 63;
        while (sum[p] == 1'b0)
            p--;
        m = (p > 62) ? (sum >> 1) : (sum << (62 - p));
        frac = '0;
        for (int i = 31; i >= 0; i--) begin
            m = mul_shift(m, m, 62);
            if (m[63]) begin
                m = m >> 1;
                frac[i] = 1'b1;
            end
        end
        v = (64'(p) - 64'sd48) * 64'sd4294967296 + $signed(frac) + 64'sd2147483648;
        mag = (v < 0) ? 64'(-v) : 64'(v);
        w = mul_shift(mag, TWO_LN2, 63);
        delta = mul_shift(w, {33'b0, scale_q}, 32);
        if (v < 0)
            x = 67'(mode_q) + $signed({3'b0, delta});
        else
            x = 67'(mode_q) - $signed({3'b0, delta});
        r.status = ST_OK;
        if (x > 67'sd2147483647) begin
            x = 67'sd2147483647;
            r.status = ST_SAT;
        end else if (x < -67'sd2147483648) begin
            x = -67'sd2147483648;
            r.status = ST_SAT;
        end
        r.variate = x[31:0];
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
            i_s_axis_tdata <= '0;
        end else begin
            if (i_s_axis_tvalid && o_s_axis_tready)
                expected_variates = {expected_variates,
                                     predict_variate(i_s_axis_tdata[32:0])};
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (pending_uniform.size() > 0 && !send_pause
                        && (quiet || $urandom_range(0, 99) >= 11)) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= {7'b0, pending_uniform.pop_front()};
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        t_variate_res e;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
            hold_cnt <= 0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (expected_variates.size() == 0) begin
                    $display("%0t: unexpected result %h/%0d", $time,
                             o_m_axis_tdata, o_m_axis_tuser);
                    errors <= errors + 1;
                end else begin
                    e = expected_variates.pop_front();
                    if (o_m_axis_tdata !== e.variate || o_m_axis_tuser !== e.status) begin
                        $display("%0t: expected %h/%0d, actual %h/%0d", $time,
                                 e.variate, e.status, o_m_axis_tdata, o_m_axis_tuser);
                        errors <= errors + 1;
                    end
                end
            end
            if (hold_go && hold_cnt < HOLD_CYCLES) begin
                hold_cnt <= hold_cnt + 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= quiet || ($urandom_range(0, 99) >= 11);
            end
        end
    end

    task automatic write_reg(t_cfg_index idx, logic [31:0] value);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        case (idx)
            CFG_MODE:  mode_q = value;
            CFG_SCALE: scale_q = value[30:0];
            default:   terms_q = value[4:0];
        endcase
    endtask

    task automatic configure(logic [31:0] mode, logic [31:0] scale, logic [31:0] terms);
        write_reg(CFG_MODE, mode);
        write_reg(CFG_SCALE, scale);
        write_reg(CFG_TERMS, terms);
    endtask

    task automatic drain();
        while (pending_uniform.size() > 0 || i_s_axis_tvalid || expected_variates.size() > 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_random(int count);
        logic [32:0] u;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(0, 9))
                0:       u = {1'b1, 32'($urandom)};
                1:       u = 33'h1_0000_0000 - 33'($urandom_range(0, 1000));
                2:       u = 33'($urandom_range(0, 1000));
                default: u = {1'b0, 32'($urandom)};
            endcase
            pending_uniform = {pending_uniform, u};
        end
    endtask

    initial begin
        logic [63:0] c[MAX_TERMS];
        logic [63:0] acc;
        c[0] = ONE_Q32;
        series_coef[0] = ONE_Q32;
        for (int k = 1; k < MAX_TERMS; k++) begin
            acc = '0;
            for (int m = 0; m < k; m++)
                acc = add_clip(acc, mul_shift(c[m], c[k-1-m], 32)
                               / (64'(m + 1) * 64'(2 * m + 1)));
            c[k] = acc;
            series_coef[k] = acc / 64'(2 * k + 1);
        end
        errors = 0;
        mode_q = 0;
        scale_q = 31'd65536;
        terms_q = 5'd8;
        send_pause = 1'b0;
        quiet = 1'b0;
        hold_go = 1'b0;
        i_rst_n = 1'b0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata = '0;
        i_m_axis_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_MODE;
        i_cfg_data = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        repeat (2) @(posedge i_clk);

        pending_uniform = '{33'h0, 33'h1, 33'h2, 33'h0_8000_0000, 33'h0_FFFF_FFFF,
                            33'h1_0000_0000, 33'h1_0000_0001, 33'h1_FFFF_FFFF,
                            33'h0_5555_5555, 33'h0_AAAA_AAAA, 33'h0_FFFF_FF00,
                            33'h0_0000_FFFF};
        drain();
        configure(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'd16);
        pending_uniform = '{33'h0, 33'h1, 33'h0_8000_0000, 33'h0_FFFF_FFF0,
                            33'h1_0000_0000, 33'h0_1000_0000};
        drain();
        configure(32'h8000_0000, 32'd0, 32'd1);
        pending_uniform = '{33'h0, 33'h0_FFFF_FFFF, 33'h0_4000_0000};
        drain();

        configure(32'd0, 32'd65536, 32'd0);
        push_random(250);
        hold_go = 1'b1;
        drain();
        configure(32'h8000_0000, 32'h7FFF_FFFF, 32'd31);
        push_random(200);
        drain();
        configure(32'h7FFF_FFFF, 32'd1 << 22, 32'd16);
        quiet = 1'b1;
        push_random(250);
        drain();
        quiet = 1'b0;
        for (int ph = 0; ph < 5; ph++) begin
            configure($urandom, $urandom & 32'h7FFF_FFFF, $urandom_range(0, 31));
            push_random(200);
            repeat (200) @(posedge i_clk);
            send_pause = 1'b1;
            while (i_s_axis_tvalid || expected_variates.size() > 0)
                @(posedge i_clk);
            send_pause = 1'b0;
            drain();
        end

        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
